/* rtl/core/ihex_pkg.sv */
// shared types and constants of the intel hex record parser
`default_nettype none

package ihex_pkg;

  // input item codes
  localparam logic IN_CHAR    = 1'b0;
  localparam logic IN_RESTART = 1'b1;

  // result kinds
  localparam logic [2:0] KIND_WRITE    = 3'd0;
  localparam logic [2:0] KIND_END      = 3'd1;
  localparam logic [2:0] KIND_TOO_LONG = 3'd2;
  localparam logic [2:0] KIND_ADDR_OVF = 3'd3;
  localparam logic [2:0] KIND_CS_FAIL  = 3'd4;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  typedef struct packed {
    logic       op;
    logic [7:0] char_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] write_addr;
    logic [7:0]  write_data;
    logic [7:0]  expected_sum;
    logic        last;
  } out_item_t;

  // datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_NIBBLE,
    OP_LEN,
    OP_AHI,
    OP_ALO,
    OP_TYPE,
    OP_DATA,
    OP_BURST_START,
    OP_READ,
    OP_WRITE_OUT,
    OP_END_OUT,
    OP_LONG_OUT,
    OP_OVF_OUT,
    OP_CSFAIL_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_colon;
    logic is_cr;
    logic too_long;
    logic addr_ovf;
    logic cs_ok;
    logic type_zero;
    logic len_zero;
    logic data_done;
    logic burst_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/core/ihex_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none

module ihex_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ihex_ctrl.sv */
// parse sequencer: record phases, halt and write burst
`default_nettype none

module ihex_ctrl import ihex_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire in_item_t in_data,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_WAIT, S_LEN_H, S_LEN_L, S_AHI_H, S_AHI_L, S_ALO_H, S_ALO_L,
    S_TYPE_H, S_TYPE_L, S_DATA_H, S_DATA_L, S_CS_H, S_CS_L,
    S_TERM, S_TERM2, S_HALT, S_RD, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_fire;

  // the burst owns the output register, characters wait
  assign in_ready = (state_r != S_RD) && (state_r != S_EMIT) && stat.out_free;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    if (state_r == S_RD) begin
      cmd.op    = OP_READ;
      state_nxt = S_EMIT;
    end else if (state_r == S_EMIT) begin
      if (stat.out_free) begin
        cmd.op    = OP_WRITE_OUT;
        state_nxt = stat.burst_last ? S_TERM : S_RD;
      end
    end else if (in_fire) begin
      if (in_data.op == IN_RESTART) begin
        cmd.op    = OP_CLEAR;
        state_nxt = S_WAIT;
      end else begin
        unique case (state_r)
          S_WAIT: begin
            if (stat.is_colon) begin
              cmd.op    = OP_CLEAR;
              state_nxt = S_LEN_H;
            end else begin
              cmd.op    = OP_END_OUT;
              state_nxt = S_HALT;
            end
          end
          S_LEN_H: begin
            cmd.op    = OP_NIBBLE;
            state_nxt = S_LEN_L;
          end
          S_LEN_L: begin
            if (stat.too_long) begin
              cmd.op    = OP_LONG_OUT;
              state_nxt = S_HALT;
            end else begin
              cmd.op    = OP_LEN;
              state_nxt = S_AHI_H;
            end
          end
          S_AHI_H: begin
            cmd.op    = OP_NIBBLE;
            state_nxt = S_AHI_L;
          end
          S_AHI_L: begin
            cmd.op    = OP_AHI;
            state_nxt = S_ALO_H;
          end
          S_ALO_H: begin
            cmd.op    = OP_NIBBLE;
            state_nxt = S_ALO_L;
          end
          S_ALO_L: begin
            if (stat.addr_ovf) begin
              cmd.op    = OP_OVF_OUT;
              state_nxt = S_HALT;
            end else begin
              cmd.op    = OP_ALO;
              state_nxt = S_TYPE_H;
            end
          end
          S_TYPE_H: begin
            cmd.op    = OP_NIBBLE;
            state_nxt = S_TYPE_L;
          end
          S_TYPE_L: begin
            cmd.op    = OP_TYPE;
            state_nxt = stat.len_zero ? S_CS_H : S_DATA_H;
          end
          S_DATA_H: begin
            cmd.op    = OP_NIBBLE;
            state_nxt = S_DATA_L;
          end
          S_DATA_L: begin
            cmd.op    = OP_DATA;
            state_nxt = stat.data_done ? S_CS_H : S_DATA_H;
          end
          S_CS_H: begin
            cmd.op    = OP_NIBBLE;
            state_nxt = S_CS_L;
          end
          S_CS_L: begin
            if (!stat.cs_ok) begin
              cmd.op    = OP_CSFAIL_OUT;
              state_nxt = S_HALT;
            end else if (stat.type_zero && !stat.len_zero) begin
              cmd.op    = OP_BURST_START;
              state_nxt = S_RD;
            end else begin
              state_nxt = S_TERM;
            end
          end
          S_TERM:  state_nxt = stat.is_cr ? S_TERM2 : S_WAIT;
          S_TERM2: state_nxt = S_WAIT;
          S_HALT:  state_nxt = S_HALT;
          default: state_nxt = S_WAIT;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_WAIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ihex_dp.sv */
// record fields, checksum, line buffer and output register
`default_nettype none

module ihex_dp import ihex_pkg::*; #(
  parameter int MAX_RECORD_BYTES = 16,
  parameter int ADDR_WIDTH       = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_data,
  input  wire ctl_cmd_t  cmd,
  output dp_stat_t       stat,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int CNT_W = $clog2(MAX_RECORD_BYTES + 1);
  localparam int IDX_W = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;
  localparam int SUM_W = ((ADDR_WIDTH > 16) ? ADDR_WIDTH : 16) + 1;
  localparam logic [SUM_W-1:0] ADDR_LIMIT = SUM_W'((64'd1 << ADDR_WIDTH) - 64'd1);

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [3:0] n;
    if (c >= 8'h30 && c <= 8'h39) begin
      n = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      n = c[3:0] + 4'd9;
    end else begin
      n = 4'hF;
    end
    return n;
  endfunction

  logic [3:0]       hi_nib_r, hi_nib_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [15:0]      addr_r, addr_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;

  logic [7:0]       byte_in;
  logic [7:0]       expect_sum;
  logic [7:0]       ram_rdata;
  logic [CNT_W:0]   cnt_inc;

  assign byte_in    = {hi_nib_r, nibble_of(in_data.char_in)};
  assign expect_sum = 8'd0 - sum_r;
  assign cnt_inc    = {1'b0, cnt_r} + (CNT_W + 1)'(1);

  always_comb begin
    stat.is_colon   = (in_data.char_in == CHAR_COLON);
    stat.is_cr      = (in_data.char_in == CHAR_CR);
    stat.too_long   = (byte_in > 8'(MAX_RECORD_BYTES));
    stat.addr_ovf   = (SUM_W'({addr_r[15:8], byte_in}) + SUM_W'(len_r)) > ADDR_LIMIT;
    stat.cs_ok      = (byte_in == expect_sum);
    stat.type_zero  = (type_r == 8'd0);
    stat.len_zero   = (len_r == '0);
    stat.data_done  = (cnt_inc >= {1'b0, len_r});
    stat.burst_last = (cnt_inc == {1'b0, len_r});
    stat.out_free   = !out_valid_r || out_ready;
  end

  ihex_ram #(
    .WIDTH (8),
    .DEPTH (MAX_RECORD_BYTES)
  ) u_line_buf (
    .clk   (clk),
    .we    (cmd.op == OP_DATA),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (byte_in),
    .re    (cmd.op == OP_READ),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    hi_nib_nxt    = hi_nib_r;
    len_nxt       = len_r;
    addr_nxt      = addr_r;
    type_nxt      = type_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (cmd.op)
      OP_CLEAR: begin
        hi_nib_nxt = '0;
        len_nxt    = '0;
        addr_nxt   = '0;
        type_nxt   = '0;
        sum_nxt    = '0;
        cnt_nxt    = '0;
      end
      OP_NIBBLE: hi_nib_nxt = nibble_of(in_data.char_in);
      OP_LEN: begin
        len_nxt = byte_in[CNT_W-1:0];
        sum_nxt = byte_in;
      end
      OP_AHI: begin
        addr_nxt = {byte_in, 8'd0};
        sum_nxt  = sum_r + byte_in;
      end
      OP_ALO: begin
        addr_nxt = {addr_r[15:8], byte_in};
        sum_nxt  = sum_r + byte_in;
      end
      OP_TYPE: begin
        type_nxt = byte_in;
        sum_nxt  = sum_r + byte_in;
        cnt_nxt  = '0;
      end
      OP_DATA: begin
        sum_nxt = sum_r + byte_in;
        cnt_nxt = cnt_inc[CNT_W-1:0];
      end
      OP_BURST_START: cnt_nxt = '0;
      OP_READ: ;
      OP_WRITE_OUT: begin
        out_nxt       = '{kind: KIND_WRITE, write_addr: addr_r + 16'(cnt_r),
                          write_data: ram_rdata, expected_sum: 8'd0,
                          last: stat.burst_last};
        out_valid_nxt = 1'b1;
        cnt_nxt       = cnt_inc[CNT_W-1:0];
      end
      OP_END_OUT: begin
        out_nxt       = '{kind: KIND_END, write_addr: 16'd0,
                          write_data: in_data.char_in, expected_sum: 8'd0, last: 1'b1};
        out_valid_nxt = 1'b1;
      end
      OP_LONG_OUT: begin
        out_nxt       = '{kind: KIND_TOO_LONG, write_addr: 16'd0,
                          write_data: 8'd0, expected_sum: 8'd0, last: 1'b1};
        out_valid_nxt = 1'b1;
      end
      OP_OVF_OUT: begin
        out_nxt       = '{kind: KIND_ADDR_OVF, write_addr: {addr_r[15:8], byte_in},
                          write_data: 8'd0, expected_sum: 8'd0, last: 1'b1};
        out_valid_nxt = 1'b1;
      end
      OP_CSFAIL_OUT: begin
        out_nxt       = '{kind: KIND_CS_FAIL, write_addr: addr_r,
                          write_data: byte_in, expected_sum: expect_sum, last: 1'b1};
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_nib_r    <= '0;
      len_r       <= '0;
      addr_r      <= '0;
      type_r      <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      hi_nib_r    <= hi_nib_nxt;
      len_r       <= len_nxt;
      addr_r      <= addr_nxt;
      type_r      <= type_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

/* rtl/core/intel_hex_record_parser_top.sv */
// top level of the intel hex record parser
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid/in_ready   | in_item_t  (op, char_in)
//   out_    | output    | out_valid/out_ready | out_item_t (kind, addr, data, sum, last)
//
// one character per cycle while the output register is free
// a good type 0 record of n bytes then emits n writes, each a line buffer
// read and then an output load, input held off meanwhile
// out_ready low while a result is held stalls both the burst and input acceptance
// synchronous reset, no clearing pass: the line buffer is only read where written
`default_nettype none

module intel_hex_record_parser_top import ihex_pkg::*; #(
  parameter int MAX_RECORD_BYTES = 16,
  parameter int ADDR_WIDTH       = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  ihex_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ihex_dp #(
    .MAX_RECORD_BYTES (MAX_RECORD_BYTES),
    .ADDR_WIDTH       (ADDR_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // no request taken while a held result would be overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready && out_valid && !out_ready))
    else $error("input accepted while result pending");

  // every non-write result closes its request
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind != KIND_WRITE) |-> out_data.last)
    else $error("error result without last");

  // error and end results halt: no further result follows without a new request
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_data.kind != KIND_WRITE) && !in_valid
    |=> !out_valid)
    else $error("result after halt");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.kind <= KIND_CS_FAIL))
    else $error("bad result kind");

endmodule

`default_nettype wire

/* verif/ihex_record_checker.sv */
// checker for the intel hex record parser: predicts results per request and compares
module ihex_record_checker import ihex_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_ready,
  input  wire in_item_t  in_data,
  input  wire logic      out_valid,
  input  wire logic      out_ready,
  input  wire out_item_t out_data,
  output int             fail_count,
  output int             pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RECORD_MAX = 16;
  localparam int ADDR_TOP   = 16'hFFFF;

  typedef enum logic [3:0] {
    S_WAIT_COLON,
    S_LEN_HI, S_LEN_LO,
    S_ADH_HI, S_ADH_LO,
    S_ADL_HI, S_ADL_LO,
    S_TYP_HI, S_TYP_LO,
    S_DAT_HI, S_DAT_LO,
    S_SUM_HI, S_SUM_LO,
    S_TERM_1, S_TERM_2
  } parse_state_t;

  parse_state_t ps;
  logic [3:0]   hi_nib;
  logic [4:0]   rec_len;
  logic [15:0]  rec_addr;
  logic [7:0]   rec_type;
  logic [7:0]   byte_sum;
  logic [4:0]   nbytes;
  logic [7:0]   data_buf [RECORD_MAX];
  logic         is_halted;

  out_item_t parsed_q [$];

  initial begin
    fail_count      = 0;
    pending_results = 0;
  end

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c[3:0];
    if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return c[3:0] + 4'd9;
    return 4'hF;
  endfunction

  task automatic clear_fields();
    ps       = S_WAIT_COLON;
    hi_nib   = '0;
    rec_len  = '0;
    rec_addr = '0;
    rec_type = '0;
    byte_sum = '0;
    nbytes   = '0;
  endtask

  task automatic push_result(input logic [2:0] kind, input logic [15:0] addr,
                             input logic [7:0] data, input logic [7:0] sum,
                             input logic last);
    out_item_t r;
    r.kind         = kind;
    r.write_addr   = addr;
    r.write_data   = data;
    r.expected_sum = sum;
    r.last         = last;
    parsed_q.push_back(r);
  endtask

  task automatic parse_request(input in_item_t req);
    logic [7:0] b;
    logic [7:0] want;
    int i;
    if (req.op == IN_RESTART) begin
      clear_fields();
      is_halted = 1'b0;
      return;
    end
    if (is_halted) return;
    case (ps)
      S_WAIT_COLON: begin
        if (req.char_in == CHAR_COLON) begin
          clear_fields();
          ps = S_LEN_HI;
        end else begin
          push_result(KIND_END, '0, req.char_in, '0, 1'b1);
          is_halted = 1'b1;
        end
      end
      S_TERM_1: ps = (req.char_in == CHAR_CR) ? S_TERM_2 : S_WAIT_COLON;
      S_TERM_2: ps = S_WAIT_COLON;
      S_LEN_HI, S_ADH_HI, S_ADL_HI, S_TYP_HI, S_DAT_HI, S_SUM_HI: begin
        hi_nib = hex_value(req.char_in);
        ps     = parse_state_t'(ps + 4'd1);
      end
      default: begin
        b = {hi_nib, hex_value(req.char_in)};
        case (ps)
          S_LEN_LO: begin
            if (b > RECORD_MAX) begin
              push_result(KIND_TOO_LONG, '0, '0, '0, 1'b1);
              is_halted = 1'b1;
            end else begin
              rec_len  = b[4:0];
              byte_sum = b;
              ps       = S_ADH_HI;
            end
          end
          S_ADH_LO: begin
            rec_addr = {b, 8'h00};
            byte_sum = byte_sum + b;
            ps       = S_ADL_HI;
          end
          S_ADL_LO: begin
            rec_addr = {rec_addr[15:8], b};
            if (int'(rec_addr) + int'(rec_len) > ADDR_TOP) begin
              push_result(KIND_ADDR_OVF, rec_addr, '0, '0, 1'b1);
              is_halted = 1'b1;
            end else begin
              byte_sum = byte_sum + b;
              ps       = S_TYP_HI;
            end
          end
          S_TYP_LO: begin
            rec_type = b;
            byte_sum = byte_sum + b;
            nbytes   = '0;
            ps       = (rec_len == 0) ? S_SUM_HI : S_DAT_HI;
          end
          S_DAT_LO: begin
            if (nbytes < RECORD_MAX) data_buf[nbytes[3:0]] = b;
            byte_sum = byte_sum + b;
            nbytes   = nbytes + 5'd1;
            ps       = (nbytes >= rec_len) ? S_SUM_HI : S_DAT_HI;
          end
          S_SUM_LO: begin
            want = 8'd0 - byte_sum;
            if (b != want) begin
              push_result(KIND_CS_FAIL, rec_addr, b, want, 1'b1);
              is_halted = 1'b1;
            end else begin
              ps = S_TERM_1;
              // only data records turn into memory writes
              if (rec_type == 8'h00) begin
                for (i = 0; i < rec_len; i++) begin
                  push_result(KIND_WRITE, rec_addr + 16'(i), data_buf[i], '0,
                              i + 1 == rec_len);
                end
              end
            end
          end
          default: ps = S_WAIT_COLON;
        endcase
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t oldest;
    if (!rst_n) begin
      clear_fields();
      is_halted = 1'b0;
      parsed_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (parsed_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, out_data);
          fail_count++;
        end else begin
          oldest = parsed_q.pop_front();
          check_field("kind", 16'(oldest.kind), 16'(out_data.kind));
          check_field("write_addr", oldest.write_addr, out_data.write_addr);
          check_field("write_data", 16'(oldest.write_data), 16'(out_data.write_data));
          check_field("expected_sum", 16'(oldest.expected_sum),
                      16'(out_data.expected_sum));
          check_field("last", 16'(oldest.last), 16'(out_data.last));
        end
      end
      if (in_valid && in_ready) parse_request(in_data);
    end
    pending_results = parsed_q.size();
  end

endmodule

/* verif/tb_intel_hex_record_parser_top.sv */
// testbench top of the intel hex record parser: hex text stimulus and verdict
module tb_intel_hex_record_parser_top import ihex_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 410;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;
  int        fail_count;
  int        pending_results;

  int idle_pct   = 0;
  int stall_left = 0;
  int sent       = 0;

  intel_hex_record_parser_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  ihex_record_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end

  // receiver stalls: mostly short, now and then long
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      out_ready  <= 1'b0;
      stall_left <= ($urandom_range(9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic int pick_gap();
    if (idle_pct == 0 || $urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_req(input logic op, input logic [7:0] ch);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{op: op, char_in: ch};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_char(input logic [7:0] ch);
    send_req(IN_CHAR, ch);
  endtask

  task automatic restart_parser();
    send_req(IN_RESTART, 8'($urandom_range(255)));
  endtask

  // hold input off until every outstanding result has drained
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [7:0] digit_char(input logic [3:0] n);
    logic [7:0] c;
    // anything outside the hex alphabet reads as 0xF
    if (n == 4'hF && $urandom_range(5) == 0) begin
      do c = 8'($urandom_range(255));
      while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"));
      return c;
    end
    if (n < 10) return "0" + n;
    return ($urandom_range(1) ? "A" : "a") + (n - 4'd10);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    send_char(digit_char(b[7:4]));
    send_char(digit_char(b[3:0]));
  endtask

  // keep = number of record bytes sent after the colon; a full record adds a terminator
  task automatic send_record(input logic [7:0] len_b, input logic [15:0] addr,
                             input logic [7:0] rtype, input logic bad_sum, input int keep);
    logic [7:0] rec_bytes [$];
    logic [7:0] sum;
    logic [7:0] d;
    int i;
    int term;
    rec_bytes = {len_b, addr[15:8], addr[7:0], rtype};
    sum = len_b + addr[15:8] + addr[7:0] + rtype;
    for (i = 0; i < ((len_b <= 16) ? int'(len_b) : 0); i++) begin
      d = 8'($urandom_range(255));
      sum += d;
      rec_bytes.push_back(d);
    end
    d = 8'd0 - sum;
    if (bad_sum) d = d ^ 8'($urandom_range(1, 255));
    rec_bytes.push_back(d);
    send_char(CHAR_COLON);
    for (i = 0; i < rec_bytes.size() && i < keep; i++) send_byte(rec_bytes[i]);
    if (keep < rec_bytes.size()) return;
    term = $urandom_range(3);
    case (term)
      0: begin
        send_char(CHAR_CR);
        send_char(8'h0A);
      end
      1: send_char(8'h0A);
      2: begin
        // second terminator slot swallows any character
        send_char(CHAR_CR);
        send_char(8'($urandom_range(255)));
      end
      default: begin
        do d = 8'($urandom_range(255));
        while (d == CHAR_CR);
        send_char(d);
      end
    endcase
  endtask

  initial begin
    logic [7:0]  len_b;
    logic [15:0] addr;
    logic [7:0]  rtype;
    int pick;
    int records;
    records = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: restart when idle, empty record at the top address,
    // bad line start, character while halted, oversize length
    restart_parser();
    send_record(8'h00, 16'hFFFF, 8'h00, 1'b0, 99);
    send_char(8'hFF);
    send_char(8'h00);
    restart_parser();
    send_record(8'h11, 16'h0000, 8'h00, 1'b0, 1);
    restart_parser();
    drain_results();

    while (sent < ITEM_TARGET) begin
      if (records % 5 == 0) begin
        case ($urandom_range(2))
          0: idle_pct <= 0;
          1: idle_pct <= 20;
          default: idle_pct <= 60;
        endcase
      end
      if (records % 7 == 6) drain_results();
      records++;

      pick  = $urandom_range(99);
      len_b = ($urandom_range(3) == 0) ? 8'd16 : 8'($urandom_range(16));
      addr  = 16'($urandom_range(16'hFFFF));
      rtype = ($urandom_range(4) != 0) ? 8'h00 :
              ($urandom_range(3) == 0) ? 8'($urandom_range(1, 255)) :
                                         8'($urandom_range(1, 5));
      if (pick < 6) begin
        len_b = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom_range(17, 255));
        send_record(len_b, addr, 8'h00, 1'b0, 1);
        restart_parser();
      end else if (pick < 14) begin
        len_b = 8'($urandom_range(1, 16));
        addr  = 16'(17'h10000 - len_b + $urandom_range(0, len_b - 1));
        send_record(len_b, addr, rtype, 1'b0, 3);
        restart_parser();
      end else if (pick < 22) begin
        send_record(len_b, addr, rtype, 1'b1, 99);
        restart_parser();
      end else if (pick < 28) begin
        repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(255)));
        restart_parser();
      end else if (pick < 32) begin
        send_record(len_b, addr, rtype, 1'b0, $urandom_range(0, 20));
        restart_parser();
      end else begin
        // a fifth of good records sit at the highest start address the overflow check accepts
        if ($urandom_range(4) == 0) addr = 16'hFFFF - len_b;
        send_record(len_b, addr, rtype, 1'b0, 99);
      end
    end

    in_valid <= 1'b0;
    idle_pct <= 0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    repeat (64) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
